// ===== design/wdpa_pkg.sv =====
// shared widths, defaults and the result record of the delta patch applier
`timescale 1ns / 1ps
package wdpa_pkg;

   localparam int DATA_W            = 16;
   localparam int ADDR_OUT_W        = 24;
   localparam int COUNT_W           = 2 * DATA_W;
   localparam int ADDR_BITS_DEFAULT = 24;

   // one result: a word write or the end marker
   typedef struct packed {
      logic [ADDR_OUT_W-1:0] write_addr;
      logic [DATA_W-1:0]     write_data;
      logic                  patch_end;
   } result_type;

endpackage

// ===== design/wdpa_if.sv =====
// request and response channel interfaces of the delta patch applier
`timescale 1ns / 1ps
interface wdpa_req_if;
   logic                       valid;
   logic                       ready;
   logic [wdpa_pkg::DATA_W-1:0] patch_word;

   modport source (output valid, output patch_word, input ready);
   modport sink   (input valid, input patch_word, output ready);
endinterface

interface wdpa_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [wdpa_pkg::ADDR_OUT_W-1:0] write_addr;
   logic [wdpa_pkg::DATA_W-1:0]     write_data;
   logic                           patch_end;

   modport source (output valid, output write_addr, output write_data, output patch_end,
                   input ready);
   modport sink   (input valid, input write_addr, input write_data, input patch_end,
                   output ready);
endinterface

// ===== design/wdpa_decode.sv =====
// patch word parser: parse mode, run counter, write pointer and result forming
`timescale 1ns / 1ps
module wdpa_decode #(
   parameter int ADDR_BITS = wdpa_pkg::ADDR_BITS_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        accept,
   input  logic [wdpa_pkg::DATA_W-1:0] patch_word,
   output logic                        has_result,
   output wdpa_pkg::result_type        result
);
   import wdpa_pkg::*;

   localparam int SUM_W = (ADDR_BITS > COUNT_W) ? ADDR_BITS : COUNT_W;
   localparam logic [ADDR_BITS-1:0] PTR_ONE = ADDR_BITS'(1);

   typedef enum logic [2:0] {
      MODE_COUNT   = 3'd0,
      MODE_SKIP    = 3'd1,
      MODE_DATA    = 3'd2,
      MODE_UNCH_LO = 3'd3,
      MODE_UNCH_HI = 3'd4
   } mode_type;

   mode_type              mode_ff, mode_in;
   logic [DATA_W-1:0]     words_left_ff, words_left_in;
   logic [ADDR_BITS-1:0]  ptr_ff, ptr_in;
   logic [DATA_W-1:0]     low_half_ff, low_half_in;
   logic [COUNT_W-1:0]    total;
   logic [DATA_W-1:0]     words_dec;

   assign total     = {patch_word, low_half_ff};
   assign words_dec = words_left_ff - DATA_W'(1);

   // next parse state and the result of the current word
   always_comb begin
      mode_in       = mode_ff;
      words_left_in = words_left_ff;
      ptr_in        = ptr_ff;
      low_half_in   = low_half_ff;
      has_result    = 1'b0;
      result        = '0;
      case (mode_ff)
         MODE_SKIP: begin
            ptr_in  = ADDR_BITS'(SUM_W'(ptr_ff) + SUM_W'(patch_word));
            mode_in = (words_left_ff != '0) ? MODE_DATA : MODE_COUNT;
         end
         MODE_DATA: begin
            has_result        = 1'b1;
            result.write_addr = ADDR_OUT_W'(ptr_ff);
            result.write_data = patch_word;
            ptr_in            = ptr_ff + PTR_ONE;
            words_left_in     = words_dec;
            if (words_dec == '0) begin
               mode_in = MODE_COUNT;
            end
         end
         MODE_UNCH_LO: begin
            low_half_in = patch_word;
            mode_in     = MODE_UNCH_HI;
         end
         MODE_UNCH_HI: begin
            mode_in = MODE_COUNT;
            if (total == '0) begin
               // end of patch: marker out, pointer back to the start
               has_result       = 1'b1;
               result.patch_end = 1'b1;
               ptr_in           = '0;
               words_left_in    = '0;
            end else begin
               ptr_in = ADDR_BITS'(SUM_W'(ptr_ff) + SUM_W'(total));
            end
         end
         default: begin
            // change count word, also taken for codes that cannot occur
            if (patch_word != '0) begin
               words_left_in = patch_word;
               mode_in       = MODE_SKIP;
            end else begin
               mode_in = MODE_UNCH_LO;
            end
         end
      endcase
   end

   // parse state, updated once per accepted request
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_COUNT;
         words_left_ff <= '0;
         ptr_ff        <= '0;
         low_half_ff   <= '0;
      end else if (accept) begin
         mode_ff       <= mode_in;
         words_left_ff <= words_left_in;
         ptr_ff        <= ptr_in;
         low_half_ff   <= low_half_in;
      end
   end

   // a nonzero count opens a run of that length
   a_count_opens_run: assert property (@(posedge clock) disable iff (reset)
      accept && mode_ff == MODE_COUNT && patch_word != '0
      |=> mode_ff == MODE_SKIP && words_left_ff == $past(patch_word))
      else $error("count word did not open a run");

   // each data word steps the pointer by one
   a_data_steps_ptr: assert property (@(posedge clock) disable iff (reset)
      accept && mode_ff == MODE_DATA |=> ptr_ff == ADDR_BITS'($past(ptr_ff) + PTR_ONE))
      else $error("pointer did not step after a data word");

   // the end marker leaves the parser ready for a new patch
   a_end_rewinds: assert property (@(posedge clock) disable iff (reset)
      accept && has_result && result.patch_end
      |=> ptr_ff == '0 && words_left_ff == '0 && mode_ff == MODE_COUNT)
      else $error("end marker did not rewind the parser");

   // no request, no change of parse state
   a_idle_holds: assert property (@(posedge clock) disable iff (reset)
      !accept |=> $stable(ptr_ff) && $stable(mode_ff) && $stable(words_left_ff))
      else $error("parse state moved without a request");

endmodule

// ===== design/wdpa_out_reg.sv =====
// response register between the parser and the response channel
`timescale 1ns / 1ps
module wdpa_out_reg (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  logic                 has_result,
   input  wdpa_pkg::result_type result,
   output logic                 slot_free,
   wdpa_rsp_if.source           rsp_chan
);
   import wdpa_pkg::*;

   logic       valid_ff;
   result_type data_ff;

   // a request may enter when no response is held or the held response leaves in the same cycle
   assign slot_free = !valid_ff || rsp_chan.ready;

   // valid flag and payload of the held response
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (accept) begin
         valid_ff <= has_result;
      end else if (rsp_chan.ready) begin
         valid_ff <= 1'b0;
      end
      if (accept && has_result) begin
         data_ff <= result;
      end
   end

   assign rsp_chan.valid      = valid_ff;
   assign rsp_chan.write_addr = data_ff.write_addr;
   assign rsp_chan.write_data = data_ff.write_data;
   assign rsp_chan.patch_end  = data_ff.patch_end;

   // a response is never overwritten while it waits
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      valid_ff && !rsp_chan.ready |-> !accept)
      else $error("request taken while a response was stalled");

endmodule

// ===== design/word_delta_patch_applier.sv =====
// top level: delta patch words in, word writes and end markers out
// a write or end marker appears on the response channel in the cycle after its request is taken
// throughput: one patch word per cycle unless a response stalls; the single response register
// is the only buffer; counts, skips and unchanged halves make no response but also wait for it
// reset (synchronous): parse mode to change count, pointer, run count and response valid cleared
`timescale 1ns / 1ps
module word_delta_patch_applier #(
   parameter int ADDR_BITS = wdpa_pkg::ADDR_BITS_DEFAULT
) (
   input  logic      clock,
   input  logic      reset,
   wdpa_req_if.sink   req_chan,
   wdpa_rsp_if.source rsp_chan
);
   import wdpa_pkg::*;

   logic       accept;
   logic       slot_free;
   logic       has_result;
   result_type result;

   // request handshake
   assign req_chan.ready = slot_free;
   assign accept         = req_chan.valid && slot_free;

   wdpa_decode #(
      .ADDR_BITS (ADDR_BITS)
   ) u_decode (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .patch_word (req_chan.patch_word),
      .has_result (has_result),
      .result     (result)
   );

   wdpa_out_reg u_out_reg (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .has_result (has_result),
      .result     (result),
      .slot_free  (slot_free),
      .rsp_chan   (rsp_chan)
   );

endmodule

// ===== bench/tb.sv =====
// self-checking bench for the delta patch applier: directed patch table, then random patches
`timescale 1ns / 1ps
module tb;
   import wdpa_pkg::*;

   localparam int PTR_W        = ADDR_BITS_DEFAULT;
   localparam int HALF_PERIOD  = 6;
   localparam int RESET_CYCLES = 6;
   localparam int LONG_HOLD    = 60;
   localparam int QUIET_LIMIT  = 2000;
   localparam int TAIL_CYCLES  = 4;
   localparam int PHASE_WORDS  = 317;
   localparam int N_DIRECTED   = 24;
   localparam int PRINT_CAP    = 100;

   // parse modes of the patch stream
   typedef enum logic [2:0] {
      EXPECT_COUNT,
      EXPECT_SKIP,
      EXPECT_DATA,
      EXPECT_UNCH_LO,
      EXPECT_UNCH_HI
   } parse_mode_type;

   // one row of the directed table; typed rows carry their own expected response
   typedef struct {
      logic [DATA_W-1:0] word;
      bit                typed;
      bit                gives_rsp;
      result_type        rsp;
   } patch_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   wdpa_req_if req_chan ();
   wdpa_rsp_if rsp_chan ();

   word_delta_patch_applier #(.ADDR_BITS(PTR_W)) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // decoder state as the bench sees it
   parse_mode_type    mode_q;
   logic [15:0]       run_left;
   logic [PTR_W-1:0]  write_ptr;
   logic [15:0]       unch_low;

   result_type        awaited_writes [$];
   logic [DATA_W-1:0] patch_words [$];
   patch_row_type     directed_rows [N_DIRECTED];

   int unsigned mismatch_count = 0;
   int unsigned quiet_cycles   = 0;
   int unsigned tx_idle_pct    = 7;
   int unsigned rx_idle_pct    = 51;
   bit          want_long_hold = 1'b0;

   always #HALF_PERIOD clock = ~clock;

   // decode one patch word; returns 1 when it makes a write or an end marker
   function automatic bit decode_patch_word(input logic [DATA_W-1:0] w, output result_type r);
      logic [COUNT_W-1:0] unchanged;
      r = '0;
      case (mode_q)
         EXPECT_SKIP: begin
            write_ptr = write_ptr + PTR_W'(w);
            mode_q    = (run_left != '0) ? EXPECT_DATA : EXPECT_COUNT;
         end
         EXPECT_DATA: begin
            r.write_addr = ADDR_OUT_W'(write_ptr);
            r.write_data = w;
            write_ptr    = write_ptr + PTR_W'(1);
            run_left     = run_left - 16'd1;
            if (run_left == '0) mode_q = EXPECT_COUNT;
            return 1'b1;
         end
         EXPECT_UNCH_LO: begin
            unch_low = w;
            mode_q   = EXPECT_UNCH_HI;
         end
         EXPECT_UNCH_HI: begin
            unchanged = {w, unch_low};
            mode_q    = EXPECT_COUNT;
            // zero unchanged count closes the patch
            if (unchanged == '0) begin
               write_ptr   = '0;
               run_left    = '0;
               r.patch_end = 1'b1;
               return 1'b1;
            end
            write_ptr = write_ptr + PTR_W'(unchanged);
         end
         default: begin
            if (w != '0) begin
               run_left = w;
               mode_q   = EXPECT_SKIP;
            end else begin
               mode_q = EXPECT_UNCH_LO;
            end
         end
      endcase
      return 1'b0;
   endfunction

   function automatic patch_row_type step_row(input logic [DATA_W-1:0] w);
      return '{w, 1'b0, 1'b0, '0};
   endfunction

   function automatic patch_row_type fixed_row(input logic [DATA_W-1:0] w, input bit gives,
                                              input logic [ADDR_OUT_W-1:0] addr,
                                              input logic [DATA_W-1:0] data, input logic fin);
      result_type r;
      r.write_addr = addr;
      r.write_data = data;
      r.patch_end  = fin;
      return '{w, 1'b1, gives, r};
   endfunction

   task automatic flag_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= PRINT_CAP) $display("mismatch at %0t: %s", $time, what);
   endtask

   // offer one patch word, called and returning at a rising edge
   task automatic offer_patch_word(input patch_row_type row);
      result_type predicted;
      bit         produced;
      while ($urandom_range(0, 99) < tx_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid      <= 1'b1;
      req_chan.patch_word <= row.word;
      @(negedge clock);
      while (!req_chan.ready) @(negedge clock);
      produced = decode_patch_word(row.word, predicted);
      if (row.typed) begin
         if (row.gives_rsp) awaited_writes.push_back(row.rsp);
      end else if (produced) begin
         awaited_writes.push_back(predicted);
      end
      @(posedge clock);
   endtask

   // stop offering until every awaited response has come
   task automatic pause_until_drained();
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (awaited_writes.size() != 0);
   endtask

   // queue the words of one random patch record, mostly well formed
   task automatic queue_patch_record();
      int unsigned pick;
      int unsigned run;
      int unsigned kept;
      logic [DATA_W-1:0] lo;
      logic [DATA_W-1:0] hi;
      logic [DATA_W-1:0] data;
      pick = $urandom_range(0, 99);
      if (pick < 55 || (pick >= 85 && pick < 93)) begin
         // changed run; the broken form stops short so later words land as data
         run = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 40) : $urandom_range(1, 6);
         kept = (pick < 55) ? run : $urandom_range(0, run - 1);
         patch_words.push_back(DATA_W'(run));
         patch_words.push_back($urandom_range(0, 1) ? DATA_W'($urandom_range(0, 3))
                                                    : DATA_W'($urandom));
         repeat (kept) begin
            case ($urandom_range(0, 9))
               0:       data = '0;
               1:       data = '1;
               default: data = DATA_W'($urandom);
            endcase
            patch_words.push_back(data);
         end
      end else if (pick < 75) begin
         // unchanged stretch, low half first
         case ($urandom_range(0, 3))
            0: begin lo = DATA_W'($urandom_range(1, 64)); hi = '0; end
            1: begin lo = '0; hi = DATA_W'($urandom_range(1, 65535)); end
            2: begin lo = DATA_W'($urandom); hi = DATA_W'($urandom); end
            default: begin lo = DATA_W'($urandom); hi = '1; end
         endcase
         patch_words.push_back('0);
         patch_words.push_back(lo);
         patch_words.push_back(hi);
      end else if (pick < 85) begin
         // end of patch
         repeat (3) patch_words.push_back('0);
      end else begin
         // stray word
         patch_words.push_back(DATA_W'($urandom_range(0, 63)));
      end
   endtask

   task automatic run_random_phase(input int unsigned tx_pct, input int unsigned rx_pct,
                                   input bit squeeze);
      int unsigned sent;
      tx_idle_pct  = tx_pct;
      rx_idle_pct <= rx_pct;
      if (squeeze) want_long_hold <= 1'b1;
      sent = 0;
      while (sent < PHASE_WORDS) begin
         queue_patch_record();
         while (patch_words.size() != 0) begin
            offer_patch_word(step_row(patch_words.pop_front()));
            sent++;
         end
      end
      pause_until_drained();
   endtask

   // response side: random stalls plus one long hold-off
   initial begin : rsp_drain
      int unsigned hold_left;
      bit          hold_served;
      hold_left     = 0;
      hold_served   = 1'b0;
      rsp_chan.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (want_long_hold && !hold_served) begin
            hold_served = 1'b1;
            hold_left   = LONG_HOLD;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= !reset && ($urandom_range(0, 99) >= rx_idle_pct);
         end
      end
   end

   // response check and watchdog, sampled mid-cycle
   always @(negedge clock) begin : rsp_check
      result_type want;
      if (!reset && rsp_chan.valid !== 1'b0 && rsp_chan.ready) begin
         if (awaited_writes.size() == 0) begin
            flag_mismatch($sformatf("unexpected response addr %h data %h end %b",
                                    rsp_chan.write_addr, rsp_chan.write_data,
                                    rsp_chan.patch_end));
         end else begin
            want = awaited_writes.pop_front();
            if (rsp_chan.write_addr !== want.write_addr)
               flag_mismatch($sformatf("write_addr %h, want %h",
                                       rsp_chan.write_addr, want.write_addr));
            if (rsp_chan.write_data !== want.write_data)
               flag_mismatch($sformatf("write_data %h, want %h",
                                       rsp_chan.write_data, want.write_data));
            if (rsp_chan.patch_end !== want.patch_end)
               flag_mismatch($sformatf("patch_end %b, want %b",
                                       rsp_chan.patch_end, want.patch_end));
         end
      end
      if (!reset && ((req_chan.valid && req_chan.ready) ||
                     (rsp_chan.valid && rsp_chan.ready)))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   initial begin
      req_chan.valid      = 1'b0;
      req_chan.patch_word = '0;
      mode_q    = EXPECT_COUNT;
      run_left  = '0;
      write_ptr = '0;
      unch_low  = '0;

      directed_rows = '{
         // first run after reset: two words from address zero
         fixed_row(16'h0002, 1'b0, '0, '0, 1'b0),
         step_row(16'h0000),
         fixed_row(16'hFFFF, 1'b1, 24'h000000, 16'hFFFF, 1'b0),
         fixed_row(16'h0000, 1'b1, 24'h000001, 16'h0000, 1'b0),
         // unchanged count that wraps the pointer round to one
         step_row(16'h0000),
         step_row(16'hFFFF),
         step_row(16'h00FF),
         // largest skip, then one write
         step_row(16'h0001),
         step_row(16'hFFFF),
         step_row(16'h1234),
         // end marker
         step_row(16'h0000),
         step_row(16'h0000),
         fixed_row(16'h0000, 1'b1, '0, '0, 1'b1),
         // pointer from zero to just below the top
         step_row(16'h0000),
         step_row(16'hFFFE),
         step_row(16'hFFFF),
         // three writes that wrap the pointer
         step_row(16'h0003),
         step_row(16'h0000),
         step_row(16'hAAAA),
         step_row(16'h5555),
         step_row(16'h8001),
         // second end marker
         fixed_row(16'h0000, 1'b0, '0, '0, 1'b0),
         step_row(16'h0000),
         fixed_row(16'h0000, 1'b1, '0, '0, 1'b1)
      };

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) offer_patch_word(directed_rows[i]);
      pause_until_drained();

      run_random_phase(7, 51, 1'b0);
      run_random_phase(51, 7, 1'b0);
      run_random_phase(0, 0, 1'b1);

      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && awaited_writes.size() == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
